[hdl/assert_macros.svh]
// Assertion macros shared by the fixed-point ALU RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/fpalu_pkg.sv]
// Package for the fixed-point ALU: mode codes and the stage word type.
// No dependencies.
`default_nettype none
package fpalu_pkg;
   localparam int unsigned DataW = 32;
   localparam int unsigned DivW  = 48;   // dividend width, |a| << FRAC_BITS (max 16)

   typedef enum logic [3:0] {
      MODE_ADD = 4'd0, MODE_SUB = 4'd1, MODE_MUL = 4'd2, MODE_DIV = 4'd3,
      MODE_MIN = 4'd4, MODE_MAX = 4'd5, MODE_INC = 4'd6, MODE_DEC = 4'd7,
      MODE_TOI = 4'd8, MODE_FRI = 4'd9
   } mode_type;

   // word handed from one divider cell to the next
   typedef struct packed {
      logic             vld;
      logic [DivW-1:0]  rem;    // partial remainder
      logic [DivW-1:0]  quo;    // dividend bits shifting out, quotient bits in
      logic [DataW-1:0] dvs;    // |b|
      logic             neg;    // quotient negative
      logic             dz;     // divide by zero
      logic             isdiv;  // result taken from the divider
      logic [DataW-1:0] res;    // result for non-divide modes
      logic [2:0]       cmp;    // less, equal, greater
   } stage_type;
endpackage
`default_nettype wire

[hdl/fixed_point_alu.sv]
// Fixed-point ALU top level: front stages, chain of divider cells, output stage.
// Depends on fpalu_pkg, fpalu_cell and assert_macros.svh.
// Every mode takes the same path: request register, head register, then
//    48 restoring-division cells each producing one quotient bit, then the output register.
// Throughput: one word per cycle; the whole pipe advances when the output
//    register is empty or being taken (a stall freezes every stage).
// Reset: synchronous, active high, clears all valid bits; payload is not reset.
`default_nettype none
module fixed_point_alu
   import fpalu_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [3:0]        req_mode,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic signed [31:0]     rsp_result_value,
   output logic                   rsp_a_less,
   output logic                   rsp_a_equal,
   output logic                   rsp_a_greater,
   output logic                   rsp_divide_by_zero
);
`include "assert_macros.svh"

   logic adv;

   // ---- stage 1: register the request word ----
   logic                    s1_vld_ff;
   logic [3:0]              s1_mode_ff;
   logic signed [DataW-1:0] s1_a_ff, s1_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
      if (adv) begin
         s1_mode_ff <= req_mode;
         s1_a_ff    <= req_operand_a;
         s1_b_ff    <= req_operand_b;
      end
   end

   // ---- stage 2: multiply, simple ops, divider setup ----
   logic signed [2*DataW-1:0] prod;
   logic signed [2*DataW-1:0] prod_sh;
   logic [DataW-1:0]          abs_a, abs_b;
   logic                      lt, eq, gt;
   stage_type                 head_in;
   mode_type                  md;

   always_comb begin
      md      = mode_type'(s1_mode_ff);
      lt      = s1_a_ff < s1_b_ff;
      eq      = s1_a_ff == s1_b_ff;
      gt      = s1_a_ff > s1_b_ff;
      prod    = s1_a_ff * s1_b_ff;
      prod_sh = prod >>> FRAC_BITS;
      abs_a   = s1_a_ff[DataW-1] ? DataW'(-s1_a_ff) : DataW'(s1_a_ff);
      abs_b   = s1_b_ff[DataW-1] ? DataW'(-s1_b_ff) : DataW'(s1_b_ff);
      head_in       = '0;
      head_in.vld   = s1_vld_ff;
      head_in.cmp   = {lt, eq, gt};
      head_in.dvs   = abs_b;
      head_in.quo   = DivW'({{(DivW-DataW){1'b0}}, abs_a} << FRAC_BITS);
      head_in.neg   = s1_a_ff[DataW-1] ^ s1_b_ff[DataW-1];
      head_in.isdiv = (md == MODE_DIV);
      head_in.dz    = (md == MODE_DIV) && (s1_b_ff == '0);
      case (s1_mode_ff)
         MODE_ADD: head_in.res = DataW'(s1_a_ff + s1_b_ff);
         MODE_SUB: head_in.res = DataW'(s1_a_ff - s1_b_ff);
         MODE_MUL: head_in.res = prod_sh[DataW-1:0];
         MODE_MIN: head_in.res = lt ? s1_a_ff : s1_b_ff;
         MODE_MAX: head_in.res = gt ? s1_a_ff : s1_b_ff;
         MODE_INC: head_in.res = DataW'(s1_a_ff + 32'sd1);
         MODE_DEC: head_in.res = DataW'(s1_a_ff - 32'sd1);
         MODE_TOI: head_in.res = DataW'(s1_a_ff >>> FRAC_BITS);
         MODE_FRI: head_in.res = DataW'(s1_a_ff <<< FRAC_BITS);
         default:  head_in.res = '0;
      endcase
   end

   // head register (the multiply result is registered here)
   stage_type head_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.vld <= 1'b0;
      end else if (adv) begin
         head_ff.vld <= head_in.vld;
      end
      if (adv) begin
         head_ff.rem <= head_in.rem;   head_ff.quo <= head_in.quo;
         head_ff.dvs <= head_in.dvs;   head_ff.neg <= head_in.neg;
         head_ff.dz  <= head_in.dz;    head_ff.isdiv <= head_in.isdiv;
         head_ff.res <= head_in.res;   head_ff.cmp <= head_in.cmp;
      end
   end

   // ---- divider chain ----
   stage_type chain [DivW+1];
   assign chain[0] = head_ff;
   for (genvar i = 0; i < DivW; i++) begin : g_cell
      fpalu_cell u_cell (
         .clock (clock), .reset (reset), .adv (adv),
         .prev  (chain[i]), .curr (chain[i+1])
      );
   end

   // ---- output register ----
   stage_type        tail;
   logic [DataW-1:0] qsig;
   logic             out_vld_ff;
   logic [DataW-1:0] out_res_ff, out_res_in;
   logic [2:0]       out_cmp_ff;
   logic             out_dz_ff;

   assign tail = chain[DivW];
   always_comb begin
      qsig = tail.neg ? DataW'(-tail.quo[DataW-1:0]) : tail.quo[DataW-1:0];
      if (tail.dz)         out_res_in = '0;
      else if (tail.isdiv) out_res_in = qsig;
      else                 out_res_in = tail.res;
   end

   assign adv = !out_vld_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= tail.vld;
      end
      if (adv) begin
         out_res_ff <= out_res_in;
         out_cmp_ff <= tail.cmp;
         out_dz_ff  <= tail.dz;
      end
   end

   assign req_stall          = !adv;
   assign rsp_valid          = out_vld_ff;
   assign rsp_result_value   = out_res_ff;
   assign rsp_a_less         = out_cmp_ff[2];
   assign rsp_a_equal        = out_cmp_ff[1];
   assign rsp_a_greater      = out_cmp_ff[0];
   assign rsp_divide_by_zero = out_dz_ff;

   // exactly one compare flag per result word
   `ASSERT_IMP(a_cmp_onehot, clock, reset, rsp_valid, $onehot(out_cmp_ff),
               "compare flags not one-hot")
   // a divide by zero result is zero
   `ASSERT_IMP(a_dz_zero, clock, reset, rsp_valid && rsp_divide_by_zero,
               rsp_result_value == '0, "dz result nonzero")
   // zero divisor and equal operands means a is zero too, so never less
   `ASSERT_IMP(a_dz_cmp, clock, reset, rsp_valid && rsp_divide_by_zero && rsp_a_equal,
               rsp_a_less == 1'b0, "dz compare mismatch")
   // a stalled output word leaves the pipe frozen
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(out_res_ff), "output changed under stall")
endmodule
`default_nettype wire

[hdl/fpalu_cell.sv]
// One restoring-division cell: one quotient bit per cycle while adv is high, registered.
// Depends on fpalu_pkg.
`default_nettype none
module fpalu_cell
   import fpalu_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      adv,
   input  wire stage_type prev,
   output stage_type      curr
);
   stage_type        curr_ff, curr_in;
   logic [DivW-1:0]  shr;
   logic [DivW:0]    dif;

   always_comb begin
      curr_in = prev;
      shr     = {prev.rem[DivW-2:0], prev.quo[DivW-1]};
      dif     = {1'b0, shr} - {{(DivW-DataW+1){1'b0}}, prev.dvs};
      if (!dif[DivW]) begin
         curr_in.rem = dif[DivW-1:0];
         curr_in.quo = {prev.quo[DivW-2:0], 1'b1};
      end else begin
         curr_in.rem = shr;
         curr_in.quo = {prev.quo[DivW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         curr_ff.vld <= 1'b0;
      end else if (adv) begin
         curr_ff.vld <= curr_in.vld;
      end
      if (adv) begin
         curr_ff.rem <= curr_in.rem;   curr_ff.quo <= curr_in.quo;
         curr_ff.dvs <= curr_in.dvs;   curr_ff.neg <= curr_in.neg;
         curr_ff.dz  <= curr_in.dz;    curr_ff.isdiv <= curr_in.isdiv;
         curr_ff.res <= curr_in.res;   curr_ff.cmp <= curr_in.cmp;
      end
   end
   assign curr = curr_ff;
endmodule
`default_nettype wire
